/* src/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, constants and functions of the telegram CRC-16 checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'h0000;
  localparam logic [7:0]  START_CHAR = 8'h2F;  // '/'
  localparam logic [7:0]  END_CHAR   = 8'h21;  // '!'
  localparam logic [1:0]  LAST_DIGIT = 2'd3;   // index of the fourth trailer digit

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_BODY    = 3'b010,
    PH_TRAILER = 3'b100
  } phase_t;

  typedef struct packed {
    logic        crc_match;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic        digit_error;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  // Reflected CRC-16 update over one byte, unrolled bit by bit.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Hex digit decode, either case.
  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b0;
    h.nib = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.nib = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      h.ok  = 1'b1;
      h.nib = b[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* src/tcc_if.sv */
// ----------------------------------------------------------------------------
// tcc_if
// Valid/ready channels of the telegram CRC-16 checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tcc_res_if;
  logic        valid;
  logic        ready;
  logic        crc_match;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;
  logic        digit_error;

  modport source (output valid, output crc_match, output computed_crc,
                  output received_crc, output digit_error, input ready);
  modport sink   (input valid, input crc_match, input computed_crc,
                  input received_crc, input digit_error, output ready);
endinterface

`default_nettype wire

/* src/telegram_crc16_checker.sv */
// ----------------------------------------------------------------------------
// telegram_crc16_checker
// Checks the CRC-16 trailer of a smart-meter telegram fed one byte per item.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                            
//  in_ch    | in  | data_byte[7:0]                                     
//  out_ch   | out | crc_match, computed_crc[15:0], received_crc[15:0],
//           |     | digit_error                                        
//
//  One byte per cycle unless stalled; unrolled eight-bit CRC fold.
//  The fourth accepted trailer byte registers a result into u_buf.
//  Synchronous active-low reset returns the frame tracker to idle.
//  Two result slots: input stalls only when both hold untaken results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module telegram_crc16_checker
  import tcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  tcc_byte_if.sink  in_ch,
  tcc_res_if.source out_ch
);

  push_t res_push;
  logic  buf_ready;
  logic  in_fire;

  assign in_ch.ready = buf_ready;
  assign in_fire     = in_ch.valid && buf_ready;

  tcc_frame_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_ch.data_byte),
    .push    (res_push)
  );

  tcc_result_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .in_ready (buf_ready),
    .out_ch   (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_stall_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no pending result");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_push.valid |-> in_ch.valid && in_ch.ready)
    else $error("result produced without an accepted item");

  a_match_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.crc_match ==
      ((out_ch.computed_crc == out_ch.received_crc) && !out_ch.digit_error))
    else $error("match flag inconsistent with result fields");
`endif

endmodule

`default_nettype wire

/* src/tcc_frame_core.sv */
// ----------------------------------------------------------------------------
// tcc_frame_core
// Frame tracking, CRC accumulation, trailer decode; one byte per fired cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcc_frame_core
  import tcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  output push_t           push
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] trail_r, trail_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        bad_r, bad_nxt;
  hex_t        hx;

  always_comb begin
    hx         = hex_decode(in_byte);
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    trail_nxt  = trail_r;
    cnt_nxt    = cnt_r;
    bad_nxt    = bad_r;
    push.valid = 1'b0;
    push.res.computed_crc = crc_r;
    push.res.received_crc = {trail_r[11:0], hx.nib};
    push.res.digit_error  = bad_r | ~hx.ok;
    push.res.crc_match    = (crc_r == {trail_r[11:0], hx.nib}) && !(bad_r | ~hx.ok);
    if (in_fire) begin
      unique case (phase_r)
        PH_BODY: begin
          crc_nxt = crc_fold(crc_r, in_byte);
          if (in_byte == END_CHAR) begin
            phase_nxt = PH_TRAILER;
            trail_nxt = 16'h0000;
            cnt_nxt   = 2'd0;
            bad_nxt   = 1'b0;
          end
        end
        PH_TRAILER: begin
          trail_nxt = {trail_r[11:0], hx.nib};
          bad_nxt   = bad_r | ~hx.ok;
          cnt_nxt   = cnt_r + 2'd1;
          if (cnt_r == LAST_DIGIT) begin
            push.valid = 1'b1;
            phase_nxt  = PH_IDLE;
          end
        end
        default: begin
          // idle; any stray code behaves as idle
          phase_nxt = PH_IDLE;
          if (in_byte == START_CHAR) begin
            crc_nxt   = crc_fold(CRC_INIT, in_byte);
            phase_nxt = PH_BODY;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r   <= crc_nxt;
    trail_r <= trail_nxt;
    bad_r   <= bad_nxt;
  end

endmodule

`default_nettype wire

/* src/tcc_result_buf.sv */
// ----------------------------------------------------------------------------
// tcc_result_buf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcc_result_buf
  import tcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       in_ready,
  tcc_res_if.source  out_ch
);

  res_t       head_r, head_nxt;
  res_t       skid_r, skid_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop      = out_ch.valid && out_ch.ready;
  assign in_ready = (cnt_r != 2'd2);

  always_comb begin
    head_nxt = head_r;
    skid_nxt = skid_r;
    cnt_nxt  = cnt_r;
    unique case ({push.valid, pop})
      2'b01: begin
        head_nxt = skid_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b10: begin
        if (cnt_r == 2'd0) head_nxt = push.res;
        else               skid_nxt = push.res;
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b11: begin
        // drain head and refill in the same cycle
        if (cnt_r == 2'd1) begin
          head_nxt = push.res;
        end else begin
          head_nxt = skid_r;
          skid_nxt = push.res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.crc_match    = head_r.crc_match;
  assign out_ch.computed_crc = head_r.computed_crc;
  assign out_ch.received_crc = head_r.received_crc;
  assign out_ch.digit_error  = head_r.digit_error;

endmodule

`default_nettype wire
